/* rtl/fast10_pkg.sv */
// ----------------------------------------------------------------------------
// FAST-10 corner detector package
// Shared types and constants for the corner detector: window geometry, the
// radius-3 circle offsets, register indexes and the result record.
// ----------------------------------------------------------------------------
package fast10_pkg;

   localparam int PIX_W      = 8;
   localparam int WIN        = 7;
   localparam int HALF       = 3;
   localparam int LINES      = 6;
   localparam int COLUMN_W   = PIX_W * WIN;
   localparam int LINE_W     = PIX_W * LINES;
   localparam int CIRCLE_LEN = 16;
   localparam int RUN_LEN    = 10;
   localparam int RSP_DEPTH  = 4;

   localparam int CIRCLE_DX [CIRCLE_LEN] =
      '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
   localparam int CIRCLE_DY [CIRCLE_LEN] =
      '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [7:0]  THRESHOLD_RESET    = 8'd20;
   localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] IMAGE_HEIGHT_RESET = 12'd480;

   // Position of a window centre, carried alongside the request.
   typedef struct packed {
      logic        valid;
      logic [10:0] col;
      logic [11:0] row;
   } centre_type;

   typedef struct packed {
      logic        centre_valid;
      logic [10:0] centre_col;
      logic [11:0] centre_row;
      logic        is_corner;
   } rsp_type;

endpackage

/* rtl/fast10_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module fast10_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fast10_window.sv */
// ----------------------------------------------------------------------------
// FAST-10 window and segment test
// Holds the 7x7 window of pixel columns and tests its centre against the
// 16-pixel circle, producing one result record per shifted column.
// ----------------------------------------------------------------------------
module fast10_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  logic [fast10_pkg::COLUMN_W-1:0] column,
   input  fast10_pkg::centre_type       centre_in,
   input  logic [7:0]                   threshold,
   output logic                         push_valid,
   output fast10_pkg::rsp_type          push_data
);
   import fast10_pkg::*;

   logic [COLUMN_W-1:0] window_ff [WIN];
   logic                s2_valid_ff;
   centre_type          s2_centre_ff;

   logic [PIX_W-1:0]    centre_px;
   logic [PIX_W-1:0]    lo_bound;
   logic [PIX_W-1:0]    hi_bound;
   logic [PIX_W:0]      hi_sum;
   logic [PIX_W-1:0]    circle_px [CIRCLE_LEN];
   logic [CIRCLE_LEN-1:0] dark;
   logic [CIRCLE_LEN-1:0] bright;
   logic                corner;

   function automatic logic has_run_of_ten(input logic [CIRCLE_LEN-1:0] mask);
      logic found;
      logic run;
      found = 1'b0;
      for (int i = 0; i < CIRCLE_LEN; i++) begin
         run = 1'b1;
         for (int j = 0; j < RUN_LEN; j++) begin
            run = run & mask[(i + j) & (CIRCLE_LEN - 1)];
         end
         found = found | run;
      end
      return found;
   endfunction

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int x = 0; x < WIN - 1; x++) begin
            window_ff[x] <= window_ff[x + 1];
         end
         window_ff[WIN - 1] <= column;
         s2_centre_ff <= centre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= shift_en;
      end
   end

   // Both bounds saturate, so where the upper bound clips at 255 no pixel is bright.
   always_comb begin
      centre_px = window_ff[HALF][PIX_W*HALF +: PIX_W];
      lo_bound  = (centre_px > threshold) ? centre_px - threshold : '0;
      hi_sum    = {1'b0, centre_px} + {1'b0, threshold};
      hi_bound  = hi_sum[PIX_W] ? {PIX_W{1'b1}} : hi_sum[PIX_W-1:0];
      for (int i = 0; i < CIRCLE_LEN; i++) begin
         circle_px[i] = window_ff[HALF + CIRCLE_DX[i]][PIX_W*(HALF + CIRCLE_DY[i]) +: PIX_W];
         dark[i]      = circle_px[i] < lo_bound;
         bright[i]    = circle_px[i] > hi_bound;
      end
      corner = has_run_of_ten(dark) | has_run_of_ten(bright);
   end

   assign push_valid             = s2_valid_ff;
   assign push_data.centre_valid = s2_centre_ff.valid;
   assign push_data.centre_col   = s2_centre_ff.col;
   assign push_data.centre_row   = s2_centre_ff.row;
   assign push_data.is_corner    = s2_centre_ff.valid & corner;

endmodule

/* rtl/fast10_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// FAST-10 result queue
// Small queue that holds finished result records until the output side
// takes them, so that the pipeline never has to stall.
// ----------------------------------------------------------------------------
module fast10_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  fast10_pkg::rsp_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fast10_pkg::rsp_type pop_data
);
   import fast10_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);

   rsp_type          entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[head_ff];

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push_valid ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + (PTR_W + 1)'(push_valid) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/fast10_corner_detector.sv */
// ----------------------------------------------------------------------------
// FAST-10 corner detector
// Raster pixel stream in, one FAST-10 result per pixel out. Six line buffers
// in one RAM feed a 7x7 window whose centre gets the segment test.
// ----------------------------------------------------------------------------
//  Channel | Direction | Carries
//  req_    | in        | pixel, frame_start
//  rsp_    | out       | centre_valid, centre_col, centre_row, is_corner
//  csr_    | in        | register index and data (threshold, width, height)
//
//  One pixel is accepted every cycle while the result queue has a free credit;
//  the line RAM is read when a request is accepted and written back in the
//  next cycle, so its single port pair sets the rate. A result passes the stage
//  1 and stage 2 registers before entering the output queue. Reset clears the
//  counters, flags and queue pointers and loads the configuration registers;
//  the line RAM needs no clearing pass. Requests stop only when the four-entry
//  result queue is fully booked by results still in flight or waiting.
// ----------------------------------------------------------------------------
module fast10_corner_detector #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_centre_valid,
   output logic [10:0] rsp_centre_col,
   output logic [11:0] rsp_centre_row,
   output logic        rsp_is_corner,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_data
);
   import fast10_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CNT_W  = ((ADDR_W > 12) ? ADDR_W : 12) + 1;
   localparam logic [CNT_W-1:0] MAX_W_C = CNT_W'(MAX_WIDTH);
   localparam int CREDIT_W = $clog2(RSP_DEPTH) + 1;

   // Configuration registers
   logic [7:0]  threshold_ff, threshold_in;
   logic [11:0] width_ff, width_in;
   logic [11:0] height_ff, height_in;

   // Position counters
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [11:0]       row_ff, row_in;

   logic [CREDIT_W-1:0] credit_ff, credit_in;

   // Stage 1: line RAM data returns
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [7:0]        s1_pixel_ff;
   centre_type        s1_centre_ff;
   logic              fwd_hit_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   logic              req_accept;
   logic              rsp_pop;
   logic [ADDR_W-1:0] col_cur;
   logic [11:0]       row_cur;
   logic [CNT_W-1:0]  col_ext;
   logic [CNT_W-1:0]  col_inc;
   logic [12:0]       row_inc;
   logic              col_wrap;
   centre_type        centre_cur;
   logic [CNT_W-1:0]  col_less_half;

   logic [LINE_W-1:0]   line_rdata;
   logic [LINE_W-1:0]   line_old;
   logic [COLUMN_W-1:0] fresh_column;
   logic [LINE_W-1:0]   line_wdata;

   logic    push_valid;
   rsp_type push_data;
   rsp_type pop_data;

   assign req_ready  = (credit_ff < CREDIT_W'(RSP_DEPTH));
   assign req_accept = req_valid && req_ready;
   assign rsp_pop    = rsp_valid && rsp_ready;
   assign csr_ready  = 1'b1;

   // ---------------- configuration ----------------
   always_comb begin
      threshold_in = threshold_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_in = csr_data[7:0];
            CSR_IMAGE_WIDTH:  width_in     = csr_data;
            CSR_IMAGE_HEIGHT: height_in    = csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 0: position and RAM read ----------------
   always_comb begin
      col_cur       = req_frame_start ? '0 : col_ff;
      row_cur       = req_frame_start ? '0 : row_ff;
      col_ext       = CNT_W'(col_cur);
      col_inc       = col_ext + 1'b1;
      row_inc       = {1'b0, row_cur} + 13'd1;
      col_wrap      = (col_inc >= CNT_W'(width_ff)) || (col_inc >= MAX_W_C);
      col_less_half = col_ext - CNT_W'(HALF);

      centre_cur.valid = (col_ext >= CNT_W'(2 * HALF)) && (row_cur >= 12'(2 * HALF)) &&
                         (col_ext < CNT_W'(width_ff)) && (row_cur < height_ff);
      centre_cur.col   = centre_cur.valid ? col_less_half[10:0] : '0;
      centre_cur.row   = centre_cur.valid ? row_cur - 12'(HALF) : '0;

      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = (row_inc >= {1'b0, height_ff}) ? '0 : row_inc[11:0];
         end else begin
            col_in = col_inc[ADDR_W-1:0];
            row_in = row_cur;
         end
      end

      credit_in = credit_ff + CREDIT_W'(req_accept) - CREDIT_W'(rsp_pop);
   end

   // ---------------- stage 1: merge and write back ----------------
   // A read issued in the same cycle as a write to the same entry sees the old
   // data, so the written line is captured and used in its place.
   always_comb begin
      line_old     = fwd_hit_ff ? fwd_data_ff : line_rdata;
      fresh_column = {s1_pixel_ff, line_old};
      line_wdata   = fresh_column[COLUMN_W-1:PIX_W];
   end

   fast10_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH),
      .ADDR_W(ADDR_W)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (s1_valid_ff),
      .wr_addr(s1_addr_ff),
      .wr_data(line_wdata),
      .rd_en  (req_accept),
      .rd_addr(col_cur),
      .rd_data(line_rdata)
   );

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff   <= col_cur;
         s1_pixel_ff  <= req_pixel;
         s1_centre_ff <= centre_cur;
         fwd_data_ff  <= line_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= IMAGE_WIDTH_RESET;
         height_ff    <= IMAGE_HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         credit_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         credit_ff    <= credit_in;
         s1_valid_ff  <= req_accept;
         if (req_accept) begin
            fwd_hit_ff <= s1_valid_ff && (s1_addr_ff == col_cur);
         end
      end
   end

   // ---------------- stage 2: window and segment test ----------------
   fast10_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_valid_ff),
      .column    (fresh_column),
      .centre_in (s1_centre_ff),
      .threshold (threshold_ff),
      .push_valid(push_valid),
      .push_data (push_data)
   );

   fast10_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (pop_data)
   );

   assign rsp_centre_valid = pop_data.centre_valid;
   assign rsp_centre_col   = pop_data.centre_col;
   assign rsp_centre_row   = pop_data.centre_row;
   assign rsp_is_corner    = pop_data.is_corner;

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_W'(RSP_DEPTH))
      else $error("result credits exceed the queue depth");

   a_accept_books_credit: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (credit_ff != '0))
      else $error("accepted request holds no credit");

   a_forward_from_write: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && fwd_hit_ff) |-> $past(s1_valid_ff))
      else $error("line forwarding without a write in the previous cycle");

   a_invalid_centre_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_centre_valid) |->
         (rsp_centre_col == '0 && rsp_centre_row == '0 && !rsp_is_corner))
      else $error("result for a border pixel carries non-zero fields");
`endif

endmodule

/* tb/tb_fast10_corner_detector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FAST-10 corner detector testbench
// Streams grey-level frames into the detector and checks every result
// against a cycle-free predictor of the line buffers, the 7x7 window and the
// segment test. A short table of directed requests runs first. Random
// frames follow, built from noise, spots, blocks, threshold-edge and extreme
// scenes, over many register settings, including mid-frame changes, an
// oversized width and a zero width.
// ----------------------------------------------------------------------------
module tb_fast10_corner_detector;
   import fast10_pkg::*;

   localparam int MAX_W         = 2048;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 30;
   localparam int IDLE_PERCENT  = 8;

   // The spare index decodes to no register.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   localparam rsp_type IDLE_RSP = '0;

   typedef enum int {SCENE_NOISE, SCENE_SPOTS, SCENE_BLOCKS, SCENE_MARGIN, SCENE_EXTREME}
      scene_type;
   typedef enum int {FLOW_ROUGH, FLOW_FRAME, FLOW_CONTINUE} flow_type;

   typedef struct packed {
      logic [7:0] pix;
      logic       fs;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   // Every directed request lands in row 0 of the reset geometry, so the
   // typed rows expect an invalid centre with all fields cleared.
   localparam stim_row_type DIRECTED_ROWS [20] = '{
      '{8'h00, 1'b1, 1'b1, IDLE_RSP}, '{8'hFF, 1'b0, 1'b1, IDLE_RSP},
      '{8'h55, 1'b0, 1'b1, IDLE_RSP}, '{8'hAA, 1'b0, 1'b1, IDLE_RSP},
      '{8'h01, 1'b0, 1'b0, IDLE_RSP}, '{8'hFE, 1'b0, 1'b0, IDLE_RSP},
      '{8'h80, 1'b0, 1'b1, IDLE_RSP}, '{8'h7F, 1'b0, 1'b1, IDLE_RSP},
      '{8'hFF, 1'b1, 1'b1, IDLE_RSP}, '{8'h00, 1'b0, 1'b1, IDLE_RSP},
      '{8'h0F, 1'b0, 1'b1, IDLE_RSP}, '{8'hF0, 1'b0, 1'b1, IDLE_RSP},
      '{8'h33, 1'b1, 1'b1, IDLE_RSP}, '{8'hCC, 1'b0, 1'b0, IDLE_RSP},
      '{8'h00, 1'b0, 1'b1, IDLE_RSP}, '{8'hFF, 1'b0, 1'b1, IDLE_RSP},
      '{8'h00, 1'b1, 1'b1, IDLE_RSP}, '{8'hFF, 1'b1, 1'b1, IDLE_RSP},
      '{8'h5A, 1'b0, 1'b1, IDLE_RSP}, '{8'hA5, 1'b0, 1'b0, IDLE_RSP}
   };

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic [7:0]  req_pixel       = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_ready       = 1'b0;
   logic        csr_valid       = 1'b0;
   logic [1:0]  csr_index       = '0;
   logic [11:0] csr_data        = '0;
   logic        req_ready;
   logic        rsp_valid;
   logic        rsp_centre_valid;
   logic [10:0] rsp_centre_col;
   logic [11:0] rsp_centre_row;
   logic        rsp_is_corner;
   logic        csr_ready;

   // Predictor state.
   logic [7:0]  thr;
   logic [11:0] img_w;
   logic [11:0] img_h;
   logic [7:0]  line_mem [MAX_W][LINES];
   logic [7:0]  win [WIN][WIN];
   int unsigned col_cnt;
   int unsigned row_cnt;
   int unsigned col_fill [MAX_W];
   rsp_type     expected_q [$];

   // A raised width over columns not yet filled six times must restart the frame.
   bit          restart_due;
   bit          send_idle_on;
   bit          recv_stall_on;

   scene_type   scene_kind;
   logic [7:0]  scene_lo;
   logic [7:0]  scene_hi;
   int unsigned block_sz;

   int unsigned n_items;
   int unsigned n_random;
   int unsigned n_results;
   int unsigned n_valid;
   int unsigned n_corner_hits;
   int unsigned n_csr;
   int unsigned n_errors;
   int unsigned cycles;

   fast10_corner_detector #(
      .MAX_WIDTH(MAX_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_centre_valid(rsp_centre_valid),
      .rsp_centre_col  (rsp_centre_col),
      .rsp_centre_row  (rsp_centre_row),
      .rsp_is_corner   (rsp_is_corner),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycles, expected_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= recv_stall_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_result();
   end

   task automatic note_mismatch(input string what);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%0t ns: %s", $time, what);
   endtask

   task automatic check_result();
      rsp_type want;
      if (expected_q.size() == 0) begin
         note_mismatch($sformatf("unexpected result col %0d row %0d",
                                 rsp_centre_col, rsp_centre_row));
         return;
      end
      want = expected_q.pop_front();
      if (rsp_centre_valid !== want.centre_valid)
         note_mismatch($sformatf("result %0d centre_valid %b, expected %b",
                                 n_results, rsp_centre_valid, want.centre_valid));
      if (rsp_centre_col !== want.centre_col)
         note_mismatch($sformatf("result %0d centre_col %0d, expected %0d",
                                 n_results, rsp_centre_col, want.centre_col));
      if (rsp_centre_row !== want.centre_row)
         note_mismatch($sformatf("result %0d centre_row %0d, expected %0d",
                                 n_results, rsp_centre_row, want.centre_row));
      if (rsp_is_corner !== want.is_corner)
         note_mismatch($sformatf("result %0d is_corner %b, expected %b at col %0d row %0d",
                                 n_results, rsp_is_corner, want.is_corner,
                                 want.centre_col, want.centre_row));
      n_results++;
      if (want.centre_valid)
         n_valid++;
      if (want.is_corner)
         n_corner_hits++;
   endtask

   function automatic bit has_arc_of_ten(input logic [15:0] m);
      bit run;
      for (int s = 0; s < CIRCLE_LEN; s++) begin
         run = 1'b1;
         for (int j = 0; j < RUN_LEN; j++)
            run &= m[(s + j) % CIRCLE_LEN];
         if (run)
            return 1'b1;
      end
      return 1'b0;
   endfunction

   // Segment test on the current window; both bounds saturate at the pixel range.
   function automatic logic corner_at_centre();
      logic [7:0]  centre;
      logic [7:0]  p;
      int unsigned lo;
      int unsigned hi;
      logic [15:0] dark;
      logic [15:0] bright;
      centre = win[HALF][HALF];
      lo = (centre > thr) ? int'(centre) - int'(thr) : 0;
      hi = (int'(centre) + int'(thr) > 255) ? 255 : int'(centre) + int'(thr);
      for (int i = 0; i < CIRCLE_LEN; i++) begin
         p = win[HALF + CIRCLE_DX[i]][HALF + CIRCLE_DY[i]];
         dark[i]   = (p < lo);
         bright[i] = (p > hi);
      end
      return has_arc_of_ten(dark) || has_arc_of_ten(bright);
   endfunction

   function automatic rsp_type predict_pixel(input logic [7:0] pix, input logic fs);
      int unsigned eff_w;
      int unsigned c;
      int unsigned r;
      logic [7:0]  fresh [WIN];
      rsp_type     res;
      eff_w = (img_w > MAX_W) ? MAX_W : img_w;
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = col_cnt;
      r = row_cnt;
      if (c >= MAX_W)
         c = 0;
      for (int k = 0; k < LINES; k++)
         fresh[k] = line_mem[c][k];
      fresh[LINES] = pix;
      for (int k = 0; k < LINES; k++)
         line_mem[c][k] = fresh[k + 1];
      if (col_fill[c] < LINES)
         col_fill[c]++;
      for (int x = 0; x < WIN - 1; x++)
         for (int y = 0; y < WIN; y++)
            win[x][y] = win[x + 1][y];
      for (int y = 0; y < WIN; y++)
         win[WIN - 1][y] = fresh[y];
      res = IDLE_RSP;
      if (c >= 2 * HALF && r >= 2 * HALF && c < eff_w && r < img_h) begin
         res.centre_valid = 1'b1;
         res.centre_col   = 11'(c - HALF);
         res.centre_row   = 12'(r - HALF);
         res.is_corner    = corner_at_centre();
      end
      if (c + 1 >= eff_w) begin
         col_cnt = 0;
         row_cnt = (r + 1 >= img_h) ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
      return res;
   endfunction

   function automatic bit lines_primed(input int unsigned w);
      for (int unsigned k = 0; k < w && k < MAX_W; k++)
         if (col_fill[k] < LINES)
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic send_pixel(input logic [7:0] pix, input logic fs, input logic typed,
                             input rsp_type typed_rsp);
      rsp_type res;
      while (send_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      res = predict_pixel(pix, fs);
      expected_q.insert(expected_q.size(), typed ? typed_rsp : res);
      n_items++;
   endtask

   // Waits until every expected result has come, then lets the pipeline settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [11:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_THRESHOLD: thr = data[7:0];
         CSR_IMAGE_WIDTH: begin
            img_w = data;
            if (!lines_primed(data))
               restart_due = 1'b1;
         end
         CSR_IMAGE_HEIGHT: img_h = data;
         default: ;
      endcase
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // The upper data bits of a threshold write are junk and must be dropped.
   task automatic program_frame(input logic [7:0] t, input logic [11:0] w,
                                input logic [11:0] h);
      drain();
      write_csr(CSR_THRESHOLD, {4'($urandom), t});
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic change_midframe();
      drain();
      case ($urandom_range(2))
         0: write_csr(CSR_THRESHOLD, 12'($urandom_range(255)));
         1: write_csr(CSR_IMAGE_WIDTH, 12'($urandom_range(7, int'(img_w) + 8)));
         default: write_csr(CSR_IMAGE_HEIGHT, 12'($urandom_range(7, int'(img_h) + 4)));
      endcase
   endtask

   task automatic new_scene(input scene_type kind);
      scene_kind = kind;
      scene_lo   = 8'($urandom_range(255));
      scene_hi   = 8'((int'(scene_lo) + $urandom_range(40, 215)) % 256);
      block_sz   = $urandom_range(3, 6);
   endtask

   function automatic logic [7:0] scene_pixel(input int unsigned c, input int unsigned r);
      int v;
      int t;
      t = int'(thr);
      case (scene_kind)
         SCENE_SPOTS:
            v = ($urandom_range(15) == 0) ? scene_hi : int'(scene_lo) + $urandom_range(3);
         SCENE_BLOCKS: begin
            v = ((c / block_sz + r / block_sz) % 2 == 1) ? scene_hi : scene_lo;
            if ($urandom_range(31) == 0)
               v = $urandom_range(255);
         end
         SCENE_MARGIN: begin
            case ($urandom_range(5))
               0: v = int'(scene_lo) - t - 1;
               1: v = int'(scene_lo) - t;
               2: v = int'(scene_lo) + t;
               3: v = int'(scene_lo) + t + 1;
               default: v = scene_lo;
            endcase
         end
         SCENE_EXTREME: begin
            case ($urandom_range(2))
               0: v = 0;
               1: v = 255;
               default: v = scene_lo;
            endcase
         end
         default: v = $urandom_range(255);
      endcase
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return 8'(v);
   endfunction

   task automatic stream_pixels(input int unsigned n_pix, input flow_type flow,
                                input bit mid_change);
      int unsigned turn;
      int unsigned c;
      int unsigned r;
      logic        fs;
      turn = (mid_change && n_pix > 1) ? $urandom_range(1, n_pix - 1) : n_pix;
      for (int unsigned i = 0; i < n_pix; i++) begin
         if (i == turn)
            change_midframe();
         case (flow)
            FLOW_ROUGH:
               fs = restart_due || (i == 0 && $urandom_range(9) != 0)
                    || ($urandom_range(199) == 0);
            FLOW_FRAME: fs = restart_due || i == 0;
            default: fs = restart_due;
         endcase
         c = fs ? 0 : col_cnt;
         r = fs ? 0 : row_cnt;
         send_pixel(scene_pixel(c, r), fs, 1'b0, IDLE_RSP);
         restart_due = 1'b0;
      end
   endtask

   // Mostly small well-formed frames; a few truncated, overrun or degenerate ones.
   task automatic random_phase();
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned frames;
      logic [7:0]  t;
      w = ($urandom_range(9) == 0) ? $urandom_range(0, 6)
          : ($urandom_range(7) == 0) ? $urandom_range(25, 64) : $urandom_range(7, 24);
      h = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 14);
      case ($urandom_range(5))
         0: t = 8'd0;
         1: t = 8'd255;
         default: t = 8'($urandom_range(60));
      endcase
      program_frame(t, 12'(w), 12'(h));
      new_scene(scene_type'($urandom_range(4)));
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
         n = w * h;
         if (n < 30)
            n = $urandom_range(30, 60);
         case ($urandom_range(9))
            0: n = $urandom_range(2, n);
            1: n = n + $urandom_range(1, 2 * w + 2);
            default: ;
         endcase
         stream_pixels(n, FLOW_ROUGH, $urandom_range(3) == 0);
         n_random += n;
      end
   endtask

   initial begin
      thr   = THRESHOLD_RESET;
      img_w = IMAGE_WIDTH_RESET;
      img_h = IMAGE_HEIGHT_RESET;
      for (int c = 0; c < MAX_W; c++) begin
         col_fill[c] = 0;
         for (int k = 0; k < LINES; k++)
            line_mem[c][k] = '0;
      end
      for (int x = 0; x < WIN; x++)
         for (int y = 0; y < WIN; y++)
            win[x][y] = '0;
      col_cnt       = 0;
      row_cnt       = 0;
      restart_due   = 1'b0;
      send_idle_on  = 1'b1;
      recv_stall_on = 1'b1;
      new_scene(SCENE_NOISE);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_pixel(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].fs, DIRECTED_ROWS[i].typed,
                    DIRECTED_ROWS[i].want);

      // Smallest legal frame, then a write that must change nothing.
      program_frame(8'd20, 12'd7, 12'd7);
      new_scene(SCENE_SPOTS);
      stream_pixels(3 * 49, FLOW_FRAME, 1'b0);
      drain();
      write_csr(CSR_SPARE, 12'($urandom));
      stream_pixels(49, FLOW_FRAME, 1'b0);

      while (n_random < RANDOM_ITEMS / 3)
         random_phase();
      send_idle_on  = 1'b0;
      recv_stall_on = 1'b0;
      random_phase();
      send_idle_on  = 1'b1;
      recv_stall_on = 1'b1;
      while (n_random < RANDOM_ITEMS)
         random_phase();

      // A width beyond the line store; the start of a line at that setting.
      program_frame(8'($urandom_range(5, 30)), 12'hFFF, 12'd7);
      new_scene(SCENE_BLOCKS);
      stream_pixels(40, FLOW_FRAME, 1'b0);

      // A zero width advances a row per request and wraps at the height; a
      // narrow width then brings the centre into the frame.
      program_frame(8'($urandom_range(0, 30)), 12'd0, 12'd20);
      new_scene(SCENE_NOISE);
      stream_pixels(30, FLOW_FRAME, 1'b0);
      drain();
      write_csr(CSR_IMAGE_WIDTH, 12'd7);
      stream_pixels(63, FLOW_CONTINUE, 1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Streamed %0d pixels over %0d register writes, from 7x7 frames to an",
               n_items, n_csr);
      $display("oversized width and a zero width; %0d results, %0d interior, %0d corners.",
               n_results, n_valid, n_corner_hits);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/fast10_pkg.sv
rtl/fast10_ram.sv
rtl/fast10_window.sv
rtl/fast10_rsp_fifo.sv
rtl/fast10_corner_detector.sv
tb/tb_fast10_corner_detector.sv
